// File: rtl/core/htlp_pkg.sv
package htlp_pkg;

   localparam int SLOTS_DEF      = 256;
   localparam int KEY_BYTES_DEF  = 8;
   localparam int VALUE_BITS_DEF = 32;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [63:0] FNV_MULT  = 64'h00000100000001B3;

   localparam int          FILL_W     = 9;
   localparam logic [8:0]  FILL_RESET = 9'd192;

   // action codes
   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_MUL,
      S_LOC_RD,
      S_LOC_CHK,
      S_FREE_RD,
      S_FREE_CHK,
      S_WRITE,
      S_DONE
   } state_type;

endpackage

// File: rtl/core/hash_table_linear_probe.sv
// Channel | Direction | Handshake            | Contents
// req     | in        | req_tvalid/tready    | tuser action, tdata key and value
// rsp     | out       | rsp_tvalid/tready    | tdata status, read_value, slot, count
// csr     | in        | csr_valid/csr_ready  | fill_limit
// One item at a time: one FNV round per key byte before the first zero byte (one xor
// and one 64x64 multiply, its 32-bit partial products formed in S_HASH and summed in
// S_MUL), then a read state and a check state per slot probed through the registered
// memory read. After reset a clearing pass zeroes the mark memory; no item is taken
// meanwhile. A stalled result is held in the output register; the next item is
// accepted once the previous result has been taken.
module hash_table_linear_probe #(
   parameter int SLOTS      = htlp_pkg::SLOTS_DEF,
   parameter int KEY_BYTES  = htlp_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BITS = htlp_pkg::VALUE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,  // action
   input  logic [((8*KEY_BYTES+VALUE_BITS+7)/8)*8-1:0] req_tdata, // key, value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,  // status, read_value, slot, entry_count
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [8:0]           csr_data    // fill_limit
);
   import htlp_pkg::*;

   localparam int KW = 8 * KEY_BYTES;
   localparam int AW = $clog2(SLOTS);
   localparam int CW = AW + 1;
   localparam int BW = $clog2(KEY_BYTES + 1);

   state_type state_ff, state_in;

   logic [8:0]            fill_ff;
   logic [1:0]            act_ff;
   logic [KW-1:0]         key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [63:0]           hash_ff, hash_in;
   logic [63:0]           plo_ff, phi_ff;
   logic [BW-1:0]         byte_ff, byte_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         probes_ff, probes_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            st_ff, st_in;
   logic [31:0]           rdv_ff, rdv_in;
   logic [7:0]            slot_ff, slot_in;
   logic                  ld_ff, ld_in;

   // marks: bit 1 ever used, bit 0 occupied
   logic            mk_we;
   logic [AW-1:0]   mk_waddr;
   logic [1:0]      mk_wdata, mk_rdata;
   logic            kv_we;
   logic [KW+VALUE_BITS-1:0] kv_wdata, kv_rdata;
   logic [KW-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [63:0]     key_pad;
   logic [7:0]      cur_byte;
   logic            key_hit;

   htlp_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_marks (
      .clock(clock), .wr_en(mk_we), .wr_addr(mk_waddr), .wr_data(mk_wdata),
      .rd_addr(idx_ff), .rd_data(mk_rdata));

   htlp_ram #(.WIDTH(KW + VALUE_BITS), .DEPTH(SLOTS)) u_kv (
      .clock(clock), .wr_en(kv_we), .wr_addr(idx_ff), .wr_data(kv_wdata),
      .rd_addr(idx_ff), .rd_data(kv_rdata));

   assign rd_key   = kv_rdata[KW-1:0];
   assign rd_val   = kv_rdata[KW+VALUE_BITS-1:KW];
   assign key_pad  = 64'(key_ff);
   assign cur_byte = key_pad[8*byte_ff[2:0] +: 8];
   assign key_hit  = mk_rdata[0] && (rd_key == key_ff);
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE) && !ld_ff;
   assign rsp_tvalid = ld_ff;
   assign rsp_tdata  = {5'd0, 9'(count_ff), slot_ff, rdv_ff, st_ff};

   // control and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         fill_ff   <= FILL_RESET;
         count_ff  <= '0;
         ld_ff     <= 1'b0;
         idx_ff    <= '0;
         probes_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ld_ff     <= ld_in;
         idx_ff    <= idx_in;
         probes_ff <= probes_in;
         if (csr_valid) begin
            fill_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff <= req_tuser;
         key_ff <= req_tdata[KW-1:0];
         val_ff <= req_tdata[KW+VALUE_BITS-1:KW];
      end
      if (state_ff == S_HASH) begin
         plo_ff <= (hash_in[31:0] * FNV_MULT[31:0]);
         phi_ff <= {hash_in[31:0] * FNV_MULT[63:32], 32'd0};
      end
      hash_ff <= hash_in;
      byte_ff <= byte_in;
      st_ff   <= st_in;
      rdv_ff  <= rdv_in;
      slot_ff <= slot_in;
   end

   // high-half partial product folded in during the multiply cycle
   logic [63:0] mul_hi;
   always_comb begin
      mul_hi = {hash_ff[63:32] * FNV_MULT[31:0], 32'd0};
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      byte_in   = byte_ff;
      idx_in    = idx_ff;
      probes_in = probes_ff;
      count_in  = count_ff;
      st_in     = st_ff;
      rdv_in    = rdv_ff;
      slot_in   = slot_ff;
      ld_in     = ld_ff && !rsp_tready;
      mk_we     = 1'b0;
      mk_waddr  = idx_ff;
      mk_wdata  = 2'b00;
      kv_we     = 1'b0;
      kv_wdata  = {val_ff, key_ff};
      case (state_ff)
         S_CLEAR: begin
            mk_we  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && !ld_ff) begin
               hash_in  = FNV_BASIS;
               byte_in  = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (byte_ff == BW'(KEY_BYTES) || cur_byte == 8'd0) begin
               idx_in    = hash_ff[AW-1:0];
               probes_in = '0;
               st_in     = ST_ABSENT;
               rdv_in    = '0;
               slot_in   = '0;
               state_in  = (act_ff == ACT_LOOKUP || act_ff == ACT_INSERT
                            || act_ff == ACT_REMOVE) ? S_LOC_RD : S_DONE;
            end else begin
               hash_in  = hash_ff ^ {56'd0, cur_byte};
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            hash_in  = plo_ff + phi_ff + mul_hi;
            byte_in  = byte_ff + 1'b1;
            state_in = S_HASH;
         end
         S_LOC_RD: begin
            state_in = S_LOC_CHK;
         end
         S_LOC_CHK: begin
            if (mk_rdata[1] && key_hit) begin
               st_in   = ST_OK;
               slot_in = 8'(idx_ff);
               if (act_ff == ACT_LOOKUP) begin
                  rdv_in = 32'(rd_val);
               end else if (act_ff == ACT_INSERT) begin
                  kv_we = 1'b1;
               end else begin
                  mk_we    = 1'b1;
                  mk_wdata = 2'b10;
                  if (count_ff != '0) count_in = count_ff - 1'b1;
               end
               state_in = S_DONE;
            end else if (!mk_rdata[1] || probes_ff == CW'(SLOTS - 1)) begin
               if (act_ff == ACT_INSERT) begin
                  if ({1'b0, 9'(count_ff)} + 10'd1 >= {1'b0, fill_ff}) begin
                     st_in    = ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     idx_in    = hash_ff[AW-1:0];
                     probes_in = '0;
                     state_in  = S_FREE_RD;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               idx_in    = idx_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               state_in  = S_LOC_RD;
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (!mk_rdata[0]) begin
               mk_we      = 1'b1;
               mk_wdata   = 2'b11;
               kv_we      = 1'b1;
               count_in   = count_ff + 1'b1;
               st_in      = ST_OK;
               slot_in    = 8'(idx_ff);
               state_in   = S_DONE;
            end else if (probes_ff == CW'(SLOTS - 1)) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else begin
               idx_in    = idx_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               state_in  = S_FREE_RD;
            end
         end
         S_WRITE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            ld_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// File: rtl/core/htlp_ram.sv
module htlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/htlp_checker.sv
module htlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   import htlp_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed under stall");

   // status is never the unused code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] <= ST_FULL)
      else $error("bad status");

   // no new item while a result waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("item accepted with result pending");

   // count never exceeds the slot count
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:42] == 14'd0 || rsp_tdata[55:42] <= 14'd256)
      else $error("count out of range");
endmodule

bind hash_table_linear_probe htlp_checker u_htlp_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
